// ===== hw/rtl/stsc_pkg.sv =====
// stsc_pkg: shared types, codes and the microcode rom of the seed table stream cipher
// no dependencies; imported by the top level

package stsc_pkg;

  localparam int TBL_AW    = 7;
  localparam int TBL_DEPTH = 127;
  localparam logic [TBL_AW-1:0] LAST_POS = 7'd127;

  localparam logic [1:0] KIND_SEED = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_WARM = 2'd2;
  localparam logic [1:0] KIND_DATA = 2'd3;

  typedef logic [3:0] upc_t;

  localparam upc_t U_IDLE     = 4'd0;
  localparam upc_t U_SEED     = 4'd1;
  localparam upc_t U_KEY_CHK  = 4'd2;
  localparam upc_t U_KEY_WR   = 4'd3;
  localparam upc_t U_WARM     = 4'd4;
  localparam upc_t U_DATA     = 4'd5;
  localparam upc_t U_PREP     = 4'd6;
  localparam upc_t U_FETCH    = 4'd7;
  localparam upc_t U_FETCH_LD = 4'd8;
  localparam upc_t U_STEP_A   = 4'd9;
  localparam upc_t U_STEP_B   = 4'd10;
  localparam upc_t U_FINISH   = 4'd11;

  typedef enum logic [3:0] {
    A_NONE,
    A_SEED_LOAD,
    A_KEY_CHECK,
    A_KEY_WRITE,
    A_WARM_INIT,
    A_DATA_INIT,
    A_FETCH,
    A_LOAD_CUR,
    A_STEP_ADDR,
    A_STEP_WRITE,
    A_EMIT
  } act_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_KEY_SKIP,
    C_COUNT_ZERO,
    C_CUR_OK,
    C_MORE,
    C_OUT_WAIT
  } cond_t;

  // jump to jmp when cond holds, else go to nxt
  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  jmp;
    upc_t  nxt;
  } ucode_t;

  function automatic ucode_t ucode_rom(input upc_t a);
    ucode_t w;
    unique case (a)
      U_IDLE:     w = '{A_NONE,       C_DISPATCH,   U_IDLE,    U_IDLE};
      U_SEED:     w = '{A_SEED_LOAD,  C_ALWAYS,     U_IDLE,    U_IDLE};
      U_KEY_CHK:  w = '{A_KEY_CHECK,  C_KEY_SKIP,   U_IDLE,    U_KEY_WR};
      U_KEY_WR:   w = '{A_KEY_WRITE,  C_ALWAYS,     U_IDLE,    U_IDLE};
      U_WARM:     w = '{A_WARM_INIT,  C_ALWAYS,     U_PREP,    U_PREP};
      U_DATA:     w = '{A_DATA_INIT,  C_ALWAYS,     U_PREP,    U_PREP};
      U_PREP:     w = '{A_NONE,       C_COUNT_ZERO, U_FINISH,  U_FETCH};
      U_FETCH:    w = '{A_FETCH,      C_CUR_OK,     U_STEP_A,  U_FETCH_LD};
      U_FETCH_LD: w = '{A_LOAD_CUR,   C_ALWAYS,     U_STEP_A,  U_STEP_A};
      U_STEP_A:   w = '{A_STEP_ADDR,  C_ALWAYS,     U_STEP_B,  U_STEP_B};
      U_STEP_B:   w = '{A_STEP_WRITE, C_MORE,       U_STEP_A,  U_FINISH};
      U_FINISH:   w = '{A_EMIT,       C_OUT_WAIT,   U_FINISH,  U_IDLE};
      default:    w = '{A_NONE,       C_ALWAYS,     U_IDLE,    U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/seed_table_stream_cipher_unit.sv =====
// seed table stream cipher: microcoded sequencer over a 127-byte table memory
// request kinds: seed, key byte, warm-up of WARMUP_STEPS generator steps and data byte;
// one request at a time, a new one is taken only once the sequencer is back in idle
// each generator step is a registered table read, then a write back
// reset clears control state and the table valid bits, so the table reads as zeros
// depends on stsc_pkg

module seed_table_stream_cipher_unit import stsc_pkg::*; #(
  parameter int WARMUP_STEPS = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] seed_word,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  byte_out
);

  localparam int CntW = (WARMUP_STEPS < 1) ? 1 : $clog2(WARMUP_STEPS + 1);

  upc_t              upc;
  ucode_t            uc;
  upc_t              upc_next;
  logic              take;

  logic [7:0]        mem [0:TBL_DEPTH-1];
  logic [TBL_DEPTH-1:0] valid;
  logic [7:0]        mem_rd;
  logic [7:0]        seed_byte;
  logic              hit;
  logic [7:0]        tbl_rd;

  logic [31:0]       seed_reg;
  logic [7:0]        req_byte;
  logic [TBL_AW-1:0] ptr;
  logic [TBL_AW-1:0] q_reg;
  logic [7:0]        cur;
  logic              cur_ok;
  logic [TBL_AW-1:0] kp;
  logic              key_ended;
  logic              is_data;
  logic [CntW-1:0]   count;

  logic              rd_req;
  logic [TBL_AW-1:0] rd_addr;
  logic              wr_en;
  logic [TBL_AW-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [TBL_AW-1:0] q_sum;
  logic [TBL_AW-1:0] q_new;
  logic [7:0]        step_val;
  logic              key_blocked;
  logic              emit_fire;

  assign in_ready    = (upc == U_IDLE);
  assign tbl_rd      = hit ? mem_rd : seed_byte;
  assign q_sum       = ptr + cur[TBL_AW-1:0];
  assign q_new       = (q_sum == LAST_POS) ? '0 : q_sum;
  assign step_val    = tbl_rd + {1'b0, ptr} + 8'd1;
  assign key_blocked = key_ended || (kp == LAST_POS);

  always_comb begin
    uc       = ucode_rom(upc);
    rd_addr  = ptr;
    wr_en    = 1'b0;
    wr_addr  = q_reg;
    wr_data  = step_val;
    unique case (uc.act)
      A_KEY_CHECK:  rd_addr = kp;
      A_FETCH:      rd_addr = ptr;
      A_STEP_ADDR:  rd_addr = q_new;
      A_KEY_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = kp;
        wr_data = tbl_rd ^ req_byte;
      end
      A_STEP_WRITE: wr_en = 1'b1;
      default: ;
    endcase
    rd_req = ((uc.act == A_KEY_CHECK) || (uc.act == A_FETCH) || (uc.act == A_STEP_ADDR))
             && (rd_addr != LAST_POS);
    emit_fire = (uc.act == A_EMIT) && is_data && (!out_valid || out_ready);

    unique case (uc.cond)
      C_ALWAYS:     take = 1'b1;
      C_KEY_SKIP:   take = key_blocked || (req_byte == 8'd0);
      C_COUNT_ZERO: take = (count == '0);
      C_CUR_OK:     take = cur_ok;
      C_MORE:       take = (count != CntW'(1));
      C_OUT_WAIT:   take = is_data && out_valid && !out_ready;
      default:      take = 1'b0;
    endcase

    upc_next = take ? uc.jmp : uc.nxt;
    if (uc.cond == C_DISPATCH) begin
      upc_next = U_IDLE;
      if (in_valid) begin
        unique case (kind)
          KIND_SEED: upc_next = U_SEED;
          KIND_KEY:  upc_next = U_KEY_CHK;
          KIND_WARM: upc_next = U_WARM;
          KIND_DATA: upc_next = U_DATA;
          default:   upc_next = U_IDLE;
        endcase
      end
    end
  end

  // table memory with registered read; unwritten entries fall back to the seed pattern
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_req) begin
      mem_rd    <= mem[rd_addr];
      hit       <= valid[rd_addr];
      seed_byte <= seed_reg[{rd_addr[1:0], 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= U_IDLE;
      valid     <= '0;
      seed_reg  <= '0;
      ptr       <= '0;
      kp        <= '0;
      key_ended <= 1'b0;
      cur_ok    <= 1'b0;
      is_data   <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (out_valid && out_ready && !emit_fire) out_valid <= 1'b0;
      if (in_valid && in_ready) begin
        req_byte <= byte_in;
        if (kind == KIND_SEED) seed_reg <= seed_word;
      end
      if (wr_en) valid[wr_addr] <= 1'b1;
      unique case (uc.act)
        A_SEED_LOAD: begin
          valid     <= '0;
          ptr       <= seed_reg[30:24];
          kp        <= '0;
          key_ended <= 1'b0;
          cur_ok    <= 1'b0;
        end
        A_KEY_CHECK: begin
          if (!key_blocked && (req_byte == 8'd0)) key_ended <= 1'b1;
        end
        A_KEY_WRITE: begin
          kp     <= kp + 1'b1;
          cur_ok <= 1'b0;
        end
        A_WARM_INIT: begin
          key_ended <= 1'b1;
          is_data   <= 1'b0;
          count     <= CntW'(WARMUP_STEPS);
        end
        A_DATA_INIT: begin
          is_data <= 1'b1;
          count   <= CntW'(1);
        end
        A_LOAD_CUR: begin
          cur    <= (ptr == LAST_POS) ? {1'b0, ptr} : tbl_rd;
          cur_ok <= 1'b1;
        end
        A_STEP_ADDR: q_reg <= q_new;
        A_STEP_WRITE: begin
          ptr   <= q_reg;
          cur   <= step_val;
          count <= count - CntW'(1);
        end
        A_EMIT: begin
          if (emit_fire) begin
            out_valid <= 1'b1;
            byte_out  <= req_byte ^ cur;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/stsc_checker.sv =====
// stsc_checker: port-level assertions for the seed table stream cipher
// bound to seed_table_stream_cipher_unit; no package dependencies

module stsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  kind,
  input logic [31:0] seed_word,
  input logic [7:0]  byte_in,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  byte_out
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(byte_out))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a request never produces its result in the next cycle
  a_no_shortcut: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after request");

  // a new result only comes out of a busy sequencer
  a_rose_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised while idle");

endmodule

bind seed_table_stream_cipher_unit stsc_checker u_stsc_checker (.*);
